// ===== src/frac_n_synth_divider_calc_top_macros.svh =====
// assertion helpers for the divider calculation block
`ifndef FRAC_N_SYNTH_DIVIDER_CALC_TOP_MACROS_SVH
`define FRAC_N_SYNTH_DIVIDER_CALC_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define FNSD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define FNSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fnsd_pkg.sv =====
`default_nettype none

package fnsd_pkg;

  localparam int unsigned LoW       = 12;
  localparam int unsigned VcoW      = 13;
  localparam int unsigned FracW     = 24;
  localparam int unsigned QuotW     = VcoW + FracW;
  localparam int unsigned RemW      = 7;
  localparam int unsigned MaxShift  = 7;

  localparam int unsigned VcoMaxMhz   = 5400;
  localparam int unsigned RefMhz      = 26;
  localparam int unsigned FbkSplitMhz = 3200;
  localparam int unsigned LoMinMhz    = 30;
  localparam int unsigned LoMaxMhz    = 3000;
  localparam int unsigned LoFallback  = 1918;
  localparam int unsigned LinFallback = 5;

  localparam logic [RemW-1:0] DenDiv2 = RemW'(2 * RefMhz);
  localparam logic [RemW-1:0] DenDiv4 = RemW'(4 * RefMhz);

  localparam logic [1:0] FbkCodeDiv2 = 2'h1;
  localparam logic [1:0] FbkCodeDiv4 = 2'h2;

  typedef struct packed {
    logic [11:0] lo_mhz;
    logic [2:0]  linearity;
  } in_t;

  typedef struct packed {
    logic [15:0] freq_word_one;
    logic [15:0] freq_word_two;
    logic [15:0] freq_word_three;
    logic [15:0] mixer_control_word;
    logic        lo_replaced;
    logic        linearity_replaced;
  } out_t;

  typedef struct packed {
    logic       den_sel;
    logic [2:0] lodiv_code;
    logic [2:0] lin;
    logic       lo_replaced;
    logic       linearity_replaced;
  } side_t;

  typedef struct packed {
    side_t            side;
    logic [RemW-1:0]  rem;
    logic [QuotW-1:0] acc;
  } cell_t;

endpackage

`default_nettype wire

// ===== src/fnsd_prep.sv =====
`default_nettype none

module fnsd_prep (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          in_valid,
  input  wire fnsd_pkg::in_t in_data,
  output logic               valid_r,
  output fnsd_pkg::cell_t    data_r
);

  logic [fnsd_pkg::LoW-1:0]  lo;
  logic [2:0]                lin;
  logic                      lo_rep;
  logic                      lin_rep;
  logic [2:0]                k;
  logic [fnsd_pkg::LoW+fnsd_pkg::MaxShift-1:0] lo_wide;
  logic [fnsd_pkg::LoW+fnsd_pkg::MaxShift-1:0] vco_wide;
  logic [fnsd_pkg::VcoW-1:0] vco;
  logic [2:0]                code;
  fnsd_pkg::cell_t           data_nxt;

  always_comb begin
    lo_rep  = (in_data.lo_mhz < fnsd_pkg::LoW'(fnsd_pkg::LoMinMhz)) ||
              (in_data.lo_mhz > fnsd_pkg::LoW'(fnsd_pkg::LoMaxMhz));
    lo      = lo_rep ? fnsd_pkg::LoW'(fnsd_pkg::LoFallback) : in_data.lo_mhz;
    lin_rep = (in_data.linearity == 3'd0);
    lin     = lin_rep ? 3'(fnsd_pkg::LinFallback) : in_data.linearity;
    lo_wide = {{fnsd_pkg::MaxShift{1'b0}}, lo};
    k = 3'd0;
    for (int j = 1; j <= fnsd_pkg::MaxShift; j++) begin
      if ((lo_wide << j) <= (fnsd_pkg::LoW + fnsd_pkg::MaxShift)'(fnsd_pkg::VcoMaxMhz)) begin
        k = k + 3'd1;
      end
    end
    vco_wide = lo_wide << k;
    vco      = vco_wide[fnsd_pkg::VcoW-1:0];
    unique case (k)
      3'd2:    code = 3'd2;
      3'd3:    code = 3'd3;
      3'd4:    code = 3'd4;
      3'd5:    code = 3'd5;
      default: code = 3'd1;
    endcase
    data_nxt.side.den_sel            = (vco > fnsd_pkg::VcoW'(fnsd_pkg::FbkSplitMhz));
    data_nxt.side.lodiv_code         = code;
    data_nxt.side.lin                = lin;
    data_nxt.side.lo_replaced        = lo_rep;
    data_nxt.side.linearity_replaced = lin_rep;
    data_nxt.rem                     = '0;
    data_nxt.acc                     = {vco, {fnsd_pkg::FracW{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/fnsd_div_cell.sv =====
`default_nettype none

module fnsd_div_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            valid_in,
  input  wire fnsd_pkg::cell_t data_in,
  output logic                 valid_r,
  output fnsd_pkg::cell_t      data_r
);

  logic [fnsd_pkg::RemW-1:0] den;
  logic [fnsd_pkg::RemW:0]   trial;
  logic [fnsd_pkg::RemW:0]   diff;
  logic                      qbit;
  fnsd_pkg::cell_t           data_nxt;

  always_comb begin
    den   = data_in.side.den_sel ? fnsd_pkg::DenDiv4 : fnsd_pkg::DenDiv2;
    trial = {data_in.rem, data_in.acc[fnsd_pkg::QuotW-1]};
    diff  = trial - {1'b0, den};
    qbit  = (trial >= {1'b0, den});
    data_nxt.side = data_in.side;
    data_nxt.rem  = qbit ? diff[fnsd_pkg::RemW-1:0] : trial[fnsd_pkg::RemW-1:0];
    data_nxt.acc  = {data_in.acc[fnsd_pkg::QuotW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/frac_n_synth_divider_calc_top.sv =====
// Fractional-N synthesizer divider calculation.
// Input channel in_valid/in_stall/in_data carries an LO frequency in MHz and a
// mixer linearity level; output channel out_valid/out_stall/out_data returns
// the synthesizer words, the mixer control word and the two replacement flags.
// A request is taken at a clock edge with valid high and stall low.
// A request passes in order through one setup stage (range fix, LO divider,
// VCO, feedback choice), a row of 37 restoring divider cells giving one
// quotient bit each, and the output register, whose out_data holds the result.
// Throughput: one request per cycle while in_stall is low; every cell hands
// its partial remainder and quotient to the next cell on each advancing edge.
// When out_stall holds a waiting result, the row keeps moving until its last
// cell is occupied; only then does the row freeze and in_stall rise.
// Synchronous active-low reset empties all cells and the output register;
// no results are pending after reset.
`default_nettype none

module frac_n_synth_divider_calc_top (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire fnsd_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output fnsd_pkg::out_t      out_data
);

  localparam int unsigned NumCells = fnsd_pkg::QuotW;

  logic              en;
  logic              out_take;
  logic              out_valid_r;
  fnsd_pkg::out_t    out_data_r;
  fnsd_pkg::out_t    out_data_nxt;
  logic              cell_valid [NumCells+1];
  fnsd_pkg::cell_t   cell_data  [NumCells+1];
  fnsd_pkg::cell_t   last;
  logic [8:0]        n_int;
  logic [1:0]        fcode;

  assign out_take = !out_valid_r || !out_stall;
  assign en       = out_take || !cell_valid[NumCells];
  assign in_stall = !en;

  fnsd_prep u_prep (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .valid_r  (cell_valid[0]),
    .data_r   (cell_data[0])
  );

  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    fnsd_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (cell_valid[i]),
      .data_in  (cell_data[i]),
      .valid_r  (cell_valid[i+1]),
      .data_r   (cell_data[i+1])
    );
  end

  always_comb begin
    last  = cell_data[NumCells];
    n_int = last.acc[fnsd_pkg::FracW+8:fnsd_pkg::FracW];
    fcode = last.side.den_sel ? fnsd_pkg::FbkCodeDiv4 : fnsd_pkg::FbkCodeDiv2;
    out_data_nxt.freq_word_one      = {n_int, last.side.lodiv_code, fcode, 2'b00};
    out_data_nxt.freq_word_two      = last.acc[fnsd_pkg::FracW-1:8];
    out_data_nxt.freq_word_three    = {last.acc[7:0], 8'h00};
    out_data_nxt.mixer_control_word = {1'b1, last.side.lin, last.side.lin, 9'h000};
    out_data_nxt.lo_replaced        = last.side.lo_replaced;
    out_data_nxt.linearity_replaced = last.side.linearity_replaced;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_take) begin
      out_valid_r <= cell_valid[NumCells];
    end
  end

  always_ff @(posedge clk) begin
    if (out_take) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "frac_n_synth_divider_calc_top_macros.svh"

  `FNSD_ASSERT_NOW(a_stall_cause, in_stall, cell_valid[NumCells] && out_valid_r && out_stall, "input stalled without a blocked result")
  `FNSD_ASSERT_NOW(a_n_bound, out_valid_r, out_data_r.freq_word_one[15:13] == 3'd0, "integer divider out of range")
  `FNSD_ASSERT_NEXT(a_last_held, cell_valid[NumCells] && in_stall, cell_valid[NumCells], "blocked result lost from the last cell")

endmodule

`default_nettype wire

// ===== bench/frac_n_synth_divider_calc_top_tb.sv =====
`default_nettype none

module frac_n_synth_divider_calc_top_tb;

  localparam int unsigned NumMixes    = 4;
  localparam int unsigned RandomReqs  = 1450;
  localparam int unsigned TailCycles  = 80;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned NumDirected = 24;

  localparam int unsigned DirLo[NumDirected] = '{0, 29, 30, 31, 42, 43, 84, 85, 168, 169,
                                                 337, 338, 675, 676, 1350, 1351, 1600,
                                                 1601, 2700, 2701, 3000, 3001, 4095, 1918};
  localparam int unsigned DirLin[NumDirected] = '{0, 1, 2, 3, 4, 5, 6, 7, 1, 2, 3, 4,
                                                  5, 6, 7, 1, 2, 3, 4, 5, 6,
                                                  7, 0, 5};

  typedef struct {
    fnsd_pkg::in_t req;
    bit            drain;
    int unsigned   mix;
  } lo_request_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  fnsd_pkg::in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  fnsd_pkg::out_t out_data;

  lo_request_t    lo_requests[$];
  fnsd_pkg::out_t synth_words_q[$];

  int unsigned send_idle_pct[NumMixes]  = '{0, 64, 0, 36};
  int unsigned recv_stall_pct[NumMixes] = '{0, 0, 64, 36};
  int unsigned cur_mix    = 0;
  int unsigned n_accepted = 0;
  int unsigned n_returned = 0;
  int unsigned n_checked  = 0;
  int unsigned n_errors   = 0;
  int unsigned n_lo_fallback  = 0;
  int unsigned n_lin_fallback = 0;
  int unsigned n_fbk_div4     = 0;
  int unsigned n_cycles       = 0;

  frac_n_synth_divider_calc_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  function automatic fnsd_pkg::out_t calc_synth_words(fnsd_pkg::in_t req);
    logic [19:0] lo;
    logic [2:0]  lin;
    logic [2:0]  k;
    logic [2:0]  lodiv_code;
    logic [12:0] vco;
    logic [6:0]  den;
    logic [1:0]  fcode;
    logic [12:0] n_int;
    logic [6:0]  rem;
    logic [23:0] frac;
    fnsd_pkg::out_t res;
    res.lo_replaced = 1'b0;
    res.linearity_replaced = 1'b0;
    lo  = 20'(req.lo_mhz);
    lin = req.linearity;
    if (lo < fnsd_pkg::LoMinMhz || lo > fnsd_pkg::LoMaxMhz) begin
      lo = 20'(fnsd_pkg::LoFallback);
      res.lo_replaced = 1'b1;
    end
    if (lin == 3'd0) begin
      lin = 3'(fnsd_pkg::LinFallback);
      res.linearity_replaced = 1'b1;
    end
    k = 3'd0;
    while (k < fnsd_pkg::MaxShift && (lo << (k + 1)) <= fnsd_pkg::VcoMaxMhz) k++;
    vco = 13'(lo << k);
    lodiv_code = (k inside {[1:5]}) ? k : 3'd1;
    if (vco <= fnsd_pkg::FbkSplitMhz) begin
      den   = fnsd_pkg::DenDiv2;
      fcode = fnsd_pkg::FbkCodeDiv2;
    end else begin
      den   = fnsd_pkg::DenDiv4;
      fcode = fnsd_pkg::FbkCodeDiv4;
    end
    n_int = vco / den;
    rem   = 7'(vco % den);
    frac  = 24'({rem, 24'b0} / den);
    res.freq_word_one      = {n_int[8:0], lodiv_code, fcode, 2'b00};
    res.freq_word_two      = frac[23:8];
    res.freq_word_three    = {frac[7:0], 8'b0};
    res.mixer_control_word = {1'b1, lin, lin, 9'b0};
    return res;
  endfunction

  task automatic check_field(string fname, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t mismatch on %s: expected %h, got %h", $time, fname, want, got);
      n_errors++;
    end
  endtask

  function automatic void add_request(logic [11:0] lo, logic [2:0] lin, bit drain,
                                      int unsigned mix);
    lo_request_t item;
    item.req.lo_mhz    = lo;
    item.req.linearity = lin;
    item.drain = drain;
    item.mix   = mix;
    lo_requests.push_back(item);
  endfunction

  initial begin
    forever #1 clk = ~clk;
  end

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (lo_requests.size() != 0 &&
          !(lo_requests[0].drain && (in_valid || n_accepted != n_returned)) &&
          $urandom_range(99) >= send_idle_pct[lo_requests[0].mix]) begin
        in_valid <= 1'b1;
        in_data  <= lo_requests[0].req;
        cur_mix  <= lo_requests[0].mix;
        void'(lo_requests.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct[cur_mix]);
    end
  end

  // result monitor
  always @(posedge clk) begin
    fnsd_pkg::out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        synth_words_q.push_back(calc_synth_words(in_data));
        n_accepted <= n_accepted + 1;
      end
      if (out_valid && !out_stall) begin
        n_returned <= n_returned + 1;
        if (synth_words_q.size() == 0) begin
          $display("%0t unexpected result %h with no request pending", $time, out_data);
          n_errors++;
        end else begin
          want = synth_words_q.pop_front();
          check_field("freq_word_one", want.freq_word_one, out_data.freq_word_one);
          check_field("freq_word_two", want.freq_word_two, out_data.freq_word_two);
          check_field("freq_word_three", want.freq_word_three, out_data.freq_word_three);
          check_field("mixer_control_word", want.mixer_control_word,
                      out_data.mixer_control_word);
          check_field("lo_replaced", 16'(want.lo_replaced), 16'(out_data.lo_replaced));
          check_field("linearity_replaced", 16'(want.linearity_replaced),
                      16'(out_data.linearity_replaced));
          n_checked++;
          if (want.lo_replaced) n_lo_fallback++;
          if (want.linearity_replaced) n_lin_fallback++;
          if (want.freq_word_one[3:2] == fnsd_pkg::FbkCodeDiv4) n_fbk_div4++;
        end
      end
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CycleLimit) begin
      $display("%0t timeout with %0d results outstanding", $time, synth_words_q.size());
      $display("frac_n_synth_divider_calc_top regression: fail");
      $finish;
    end
  end

  initial begin
    int unsigned mix;
    logic [11:0] lo;
    // range edges, every divider step and the feedback split
    for (int i = 0; i < NumDirected; i++) begin
      add_request(12'(DirLo[i]), 3'(DirLin[i]), 1'b0, 0);
    end
    for (int i = 0; i < RandomReqs; i++) begin
      mix = i * NumMixes / RandomReqs;
      if ($urandom_range(99) < 80) begin
        lo = 12'($urandom_range(fnsd_pkg::LoMaxMhz, fnsd_pkg::LoMinMhz));
      end else begin
        lo = 12'($urandom_range(4095, 0));
      end
      add_request(lo, 3'($urandom_range(7, 0)),
                  (i * NumMixes) % RandomReqs < NumMixes, mix);
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    while (lo_requests.size() != 0 || in_valid) @(posedge clk);
    while (synth_words_q.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    $display("%0d requests checked over four handshake mixes, with pauses to drain",
             n_checked);
    $display("%0d used the LO fallback, %0d the linearity fallback, %0d divide-by-4 feedback",
             n_lo_fallback, n_lin_fallback, n_fbk_div4);
    if (n_errors == 0) begin
      $display("frac_n_synth_divider_calc_top regression: pass");
    end else begin
      $display("frac_n_synth_divider_calc_top regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
